FILE: src/smoothstep_dissolve_transition_core_defines.svh
// Assertion macros shared by the checker of the smoothstep dissolve core.
`ifndef SMOOTHSTEP_DISSOLVE_TRANSITION_CORE_DEFINES_SVH
`define SMOOTHSTEP_DISSOLVE_TRANSITION_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define SDT_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sdt assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define SDT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdt assertion failed");

// A condition that must hold in the cycle after its trigger.
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdt assertion failed");

`endif

FILE: src/sdt_pkg.sv
// Shared types and constants of the smoothstep dissolve core.
package sdt_pkg;

	// Field widths and number formats.
	localparam int ELAPSED_W            = 20;
	localparam int RATE_W               = 19;
	localparam int MODE_W               = 2;
	localparam int WEIGHT_FRAC_BITS     = 16;
	localparam int WEIGHT_W             = WEIGHT_FRAC_BITS + 1;
	localparam int PHASE_FRAC_BITS_DEF  = 32;
	localparam int EASE_BITS            = 30;

	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-3:0] REG_PHASE_RATE = '0;
	localparam logic [RATE_W-1:0] RATE_RESET = 19'd12271;

	// Request codes.
	localparam logic              REQ_SNAP     = 1'b1;
	localparam logic [MODE_W-1:0] MODE_EFFECTS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAN   = 2'd1;

	typedef struct packed {
		logic                 req_type;
		logic [MODE_W-1:0]    req_mode;
		logic [ELAPSED_W-1:0] elapsed_us;
	} req_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] effects_weight;
		logic                heading_clean;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic step;
		logic advance;
		logic quantise;
		logic square;
		logic prepare;
		logic multiply;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic moves;
	} status_t;

endpackage

FILE: src/sdt_regs.sv
// Configuration register file with its APB-style access port.
module sdt_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sdt_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sdt_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sdt_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic [sdt_pkg::RATE_W-1:0]       phase_rate
);

	logic [sdt_pkg::RATE_W-1:0] rate_q;
	logic                       hit;

	// Registers sit on word boundaries; the byte offset bits are ignored.
	assign hit = (paddr[sdt_pkg::APB_ADDR_W-1:2] == sdt_pkg::REG_PHASE_RATE);

	// The register is written in the access phase of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= sdt_pkg::RATE_RESET;
		end else if (psel && penable && pwrite && hit) begin
			rate_q <= pwdata[sdt_pkg::RATE_W-1:0];
		end
	end

	// Reads return the register, and zero elsewhere.
	assign prdata = hit ? {{(sdt_pkg::APB_DATA_W - sdt_pkg::RATE_W){1'b0}}, rate_q}
			: '0;
	assign pready = 1'b1;
	assign phase_rate = rate_q;

endmodule

FILE: src/sdt_ctrl.sv
// Controller state machine that sequences one item through the datapath.
module sdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  sdt_pkg::status_t  status,
	output sdt_pkg::cmd_t     cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_TURN = 8'b0000_0010,
		S_ADV  = 8'b0000_0100,
		S_QNT  = 8'b0000_1000,
		S_SQR  = 8'b0001_0000,
		S_PREP = 8'b0010_0000,
		S_MUL  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	// Commands follow directly from the state; capture and load are also gated by the handshakes.
	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && req_valid;
		cmd.step     = (state_q == S_TURN);
		cmd.advance  = (state_q == S_ADV);
		cmd.quantise = (state_q == S_QNT);
		cmd.square   = (state_q == S_SQR);
		cmd.prepare  = (state_q == S_PREP);
		cmd.multiply = (state_q == S_MUL);
		cmd.load     = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	end

	// Next state: the advance step is skipped when the phase cannot move.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_TURN;
			end
			S_TURN: begin
				state_d = status.moves ? S_ADV : S_QNT;
			end
			S_ADV:  state_d = S_QNT;
			S_QNT:  state_d = S_SQR;
			S_SQR:  state_d = S_PREP;
			S_PREP: state_d = S_MUL;
			S_MUL:  state_d = S_OUT;
			S_OUT: begin
				if (cmd.load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The result register is full from its load until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: src/sdt_datapath.sv
// Datapath: ramp state, phase update and the smoothstep easing arithmetic.
module sdt_datapath #(
	parameter int PHASE_FRAC_BITS = sdt_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sdt_pkg::cmd_t               cmd,
	output sdt_pkg::status_t            status,
	input  sdt_pkg::req_t               req,
	input  logic [sdt_pkg::RATE_W-1:0]  phase_rate,
	output sdt_pkg::rsp_t               rsp
);

	localparam int PHASE_W  = PHASE_FRAC_BITS + 1;
	localparam int RATE_W   = sdt_pkg::RATE_W;
	localparam int INC_W    = sdt_pkg::ELAPSED_W + RATE_W;
	localparam int SUM_W    = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;
	localparam int EB       = sdt_pkg::EASE_BITS;
	localparam int Q_W      = EB + 1;
	localparam int SQ_W     = 2 * Q_W;
	localparam int S_W      = EB + 2;
	localparam int PROD_W   = Q_W + S_W;
	localparam int DOWN     = (PHASE_FRAC_BITS >= EB) ? PHASE_FRAC_BITS - EB : 0;
	localparam int UP       = (PHASE_FRAC_BITS >= EB) ? 0 : EB - PHASE_FRAC_BITS;
	localparam int OUT_SHIFT = 2 * EB - sdt_pkg::WEIGHT_FRAC_BITS;
	localparam int WEIGHT_W = sdt_pkg::WEIGHT_W;

	localparam logic [PHASE_W-1:0] PHASE_FULL = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
	localparam logic [63:0] RATE_MAX =
		((64'd1 << PHASE_FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam logic [63:0]       Q_RND   = (64'd1 << DOWN) >> 1;
	localparam logic [SQ_W:0]     SQ_RND  = (SQ_W + 1)'(1) << (EB - 1);
	localparam logic [S_W-1:0]    THREE   = S_W'(3) << EB;
	localparam logic [PROD_W:0]   OUT_RND = (PROD_W + 1)'(1) << (OUT_SHIFT - 1);

	// Ramp state.
	logic                  target_q;
	logic [PHASE_W-1:0]    phase_q;

	// Working registers of one item.
	logic                  type_q;
	logic [sdt_pkg::MODE_W-1:0] mode_q;
	logic [INC_W-1:0]      inc_q;
	logic [Q_W-1:0]        q_q;
	logic                  full_q;
	logic [SQ_W-1:0]       sq_q;
	logic [Q_W-1:0]        q2_q;
	logic [S_W-1:0]        s_q;
	logic [PROD_W-1:0]     prod_q;
	sdt_pkg::rsp_t         rsp_q;

	logic [RATE_W-1:0]     rate_capped;
	logic                  steer;
	logic                  want_clean;
	logic [SUM_W-1:0]      sum;
	logic [63:0]           q_wide;
	logic [SQ_W:0]         sq_round;
	logic [PROD_W:0]       w_round;
	logic [WEIGHT_W-1:0]   arrival;
	logic [WEIGHT_W-1:0]   weight;

	// The rate is held to the shortest permitted dissolve.
	assign rate_capped = ({{(64 - RATE_W){1'b0}}, phase_rate} > RATE_MAX)
			? RATE_MAX[RATE_W-1:0] : phase_rate;

	// Only the Effects and Clean modes steer the ramp.
	assign steer      = (mode_q == sdt_pkg::MODE_EFFECTS) || (mode_q == sdt_pkg::MODE_CLEAN);
	assign want_clean = (mode_q == sdt_pkg::MODE_CLEAN);
	assign status.moves = steer && (type_q != sdt_pkg::REQ_SNAP);

	// Saturating phase advance.
	assign sum = SUM_W'(phase_q) + SUM_W'(inc_q);

	// Ramp state: snap or turn round, then advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 1'b0;
			phase_q  <= PHASE_FULL;
		end else if (cmd.step && steer) begin
			if (type_q == sdt_pkg::REQ_SNAP) begin
				target_q <= want_clean;
				phase_q  <= PHASE_FULL;
			end else if (want_clean != target_q) begin
				target_q <= want_clean;
				phase_q  <= PHASE_FULL - phase_q;
			end
		end else if (cmd.advance) begin
			phase_q <= (sum > SUM_W'(PHASE_FULL)) ? PHASE_FULL : sum[PHASE_W-1:0];
		end
	end

	// Phase rounded half up to the easing format.
	assign q_wide = ((64'(phase_q) + Q_RND) >> DOWN) << UP;

	// Square rounded back to the easing format.
	assign sq_round = ({1'b0, sq_q} + SQ_RND) >> EB;

	// Eased arrival rounded to the weight format, capped, then mirrored.
	assign w_round = ({1'b0, prod_q} + OUT_RND) >> OUT_SHIFT;

	always_comb begin
		if (full_q) begin
			arrival = sdt_pkg::WEIGHT_FULL;
		end else if (w_round > (PROD_W + 1)'(sdt_pkg::WEIGHT_FULL)) begin
			arrival = sdt_pkg::WEIGHT_FULL;
		end else begin
			arrival = w_round[WEIGHT_W-1:0];
		end
	end

	assign weight = target_q ? (sdt_pkg::WEIGHT_FULL - arrival) : arrival;

	// Arithmetic sequence, one step per command.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q <= req.req_type;
			mode_q <= req.req_mode;
			inc_q  <= req.elapsed_us * rate_capped;
		end
		if (cmd.quantise) begin
			q_q    <= q_wide[Q_W-1:0];
			full_q <= (phase_q == PHASE_FULL);
		end
		if (cmd.square) begin
			sq_q <= q_q * q_q;
		end
		if (cmd.prepare) begin
			q2_q <= sq_round[Q_W-1:0];
			s_q  <= THREE - {q_q, 1'b0};
		end
		if (cmd.multiply) begin
			prod_q <= q2_q * s_q;
		end
		if (cmd.load) begin
			rsp_q.effects_weight <= weight;
			rsp_q.heading_clean  <= target_q;
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: src/smoothstep_dissolve_transition_core.sv
// Smoothstep dissolve core: one eased Effects weight per request.
// Each request is captured, then walked through the turn, advance (only for a
// frame update that moves the phase), quantise, square, prepare, multiply and
// output states; the result is registered. A new request is taken only once the
// last result is loaded, and a result that is not taken stalls the output state.
// Reset: arst_n clears the ramp to full towards Effects and the rate to 12271.
module smoothstep_dissolve_transition_core #(
	parameter int PHASE_FRAC_BITS = sdt_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sdt_pkg::req_t                   req,
	input  logic                            req_valid,
	output logic                            req_ready,
	output sdt_pkg::rsp_t                   rsp,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdt_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [sdt_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sdt_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	logic [sdt_pkg::RATE_W-1:0] phase_rate;
	sdt_pkg::cmd_t              cmd;
	sdt_pkg::status_t           status;

	// Configuration registers.
	sdt_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.phase_rate (phase_rate)
	);

	// Sequencing and handshakes.
	sdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Ramp state and arithmetic.
	sdt_datapath #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.req        (req),
		.phase_rate (phase_rate),
		.rsp        (rsp)
	);

endmodule

FILE: src/sdt_checker.sv
// Port-level checker of the smoothstep dissolve core and its bind.
`include "smoothstep_dissolve_transition_core_defines.svh"

module sdt_checker (
	input logic           clk,
	input logic           arst_n,
	input sdt_pkg::req_t  req,
	input logic           req_valid,
	input logic           req_ready,
	input sdt_pkg::rsp_t  rsp,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input logic           pready
);

	// The configuration port never inserts wait states.
	`SDT_ASSERT_HOLDS(a_pready_high, clk, arst_n, pready)

	// A delivered weight never exceeds full Effects.
	`SDT_ASSERT_IMPLIES(a_weight_range, clk, arst_n, rsp_valid,
		rsp.effects_weight <= sdt_pkg::WEIGHT_FULL)

	// A result that is not taken stays offered unchanged.
	`SDT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp))

	// Items are worked one at a time: no transfer directly after another.
	`SDT_ASSERT_NEXT(a_one_item, clk, arst_n, req_valid && req_ready, !req_ready)

endmodule

bind smoothstep_dissolve_transition_core sdt_checker u_sdt_checker (.*);
